@@ hw/rtl/can_transport_rts_cts_sender_unit_assert.svh @@
// Assertion macros for the transport sender unit checker.
// Depends on nothing; included by the checker file.
`ifndef CAN_TRANSPORT_RTS_CTS_SENDER_UNIT_ASSERT_SVH
`define CAN_TRANSPORT_RTS_CTS_SENDER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RTSCTS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RTSCTS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/rtscts_pkg.sv @@
// Shared types and codes of the transport sender unit.
// No dependencies; imported by every module of the block but the RAM.
package rtscts_pkg;

   typedef struct packed {
      logic [1:0]  func;
      logic [8:0]  byte_index;
      logic [7:0]  data_byte;
      logic [17:0] pgn_number;
      logic [8:0]  total_bytes;
      logic [63:0] rx_frame;
   } req_type;

   typedef struct packed {
      logic        has_frame;
      logic [28:0] frame_id;
      logic [63:0] frame_bytes;
      logic [3:0]  frame_len;
      logic [2:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic latch;
      logic apply;
      logic rd_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       rd_done;
      logic       burst_last;
   } sts_type;

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_RX    = 2'd2;

   localparam logic [7:0] CTL_CTS   = 8'h11;
   localparam logic [7:0] CTL_ACK   = 8'h13;
   localparam logic [7:0] CTL_ABORT = 8'hFF;
   localparam logic [7:0] CTL_RTS   = 8'h10;

   localparam logic [7:0] PF_CM = 8'hEC;
   localparam logic [7:0] PF_DT = 8'hEB;

   localparam logic [2:0] STAT_OK     = 3'd0;
   localparam logic [2:0] STAT_RSV    = 3'd1;
   localparam logic [2:0] STAT_PGN    = 3'd2;
   localparam logic [2:0] STAT_ZERO   = 3'd3;
   localparam logic [2:0] STAT_RANGE  = 3'd4;
   localparam logic [2:0] STAT_STATE  = 3'd5;
   localparam logic [2:0] STAT_LENGTH = 3'd6;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_RTS    = 2'd1;
   localparam logic [1:0] KIND_BURST  = 2'd2;

   localparam logic [1:0] SES_IDLE = 2'd0;
   localparam logic [1:0] SES_WAIT = 2'd1;
   localparam logic [1:0] SES_CONN = 2'd2;

   localparam logic [1:0] CSR_SRC  = 2'd0;
   localparam logic [1:0] CSR_DST  = 2'd1;
   localparam logic [1:0] CSR_PRIO = 2'd2;

   localparam logic [7:0] BYTE_PAD = 8'hFF;

endpackage

@@ hw/rtl/rtscts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rtscts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 448
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hw/rtl/rtscts_dp.sv @@
// Datapath: request decode, session registers, message store, frame build.
// Depends on rtscts_pkg and rtscts_ram.
module rtscts_dp #(
   parameter int STORE_BYTES = 448,
   parameter int MAX_BURST   = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  rtscts_pkg::req_type req_data,
   input  rtscts_pkg::cmd_type cmd,
   output rtscts_pkg::sts_type sts,
   input  logic                csr_valid,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_data,
   output logic                rsp_valid,
   output rtscts_pkg::rsp_type rsp_data
);
   import rtscts_pkg::*;

   localparam int AW = $clog2(STORE_BYTES);

   req_type     req_ff;
   logic [1:0]  ses_ff;
   logic [17:0] pgn_ff;
   logic [8:0]  len_ff;
   logic [6:0]  tot_ff;
   logic [7:0]  src_ff, dst_ff;
   logic [2:0]  prio_ff;
   logic [7:0]  pkt_ff, end_ff;
   logic [AW-1:0] addr_ff;
   logic [3:0]  j_ff;
   logic [55:0] buf_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic [7:0]  b [8];
   logic        pgn_ok, rsv_ok, range_bad;
   logic [2:0]  ev_status;
   logic [1:0]  ev_kind;
   logic        ev_conn, ev_clear, ev_write;
   logic [9:0]  pk_sum;
   logic [21:0] pk_prod;
   logic [7:0]  pk;
   logic [63:0] rts_bytes;
   logic [9:0]  last_len_full;
   logic [2:0]  len_p, k;
   logic [7:0]  rd_byte, keep_byte;
   logic [10:0] sm1, base;
   logic [28:0] id_cm, id_dt;
   logic [8:0]  count9, strt9;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         b[i] = req_ff.rx_frame[8*i +: 8];
      end
   end

   assign count9 = {1'b0, b[1]};
   assign strt9  = {1'b0, b[2]};
   assign pgn_ok = (req_ff.rx_frame[63:40] == {6'b0, pgn_ff});
   assign rsv_ok = (b[3] == BYTE_PAD) && (b[4] == BYTE_PAD);
   assign range_bad = (b[2] == 8'd0) || (count9 > 9'(MAX_BURST)) ||
                      ((count9 + strt9 - 9'd1) > {2'b0, tot_ff});

   // Packet count: divide by seven via a scaled reciprocal.
   assign pk_sum  = {1'b0, req_ff.total_bytes} + 10'd6;
   assign pk_prod = 22'(pk_sum) * 22'd2341;
   assign pk      = pk_prod[21:14];
   assign rts_bytes = {6'b0, req_ff.pgn_number, BYTE_PAD, pk,
                       7'b0, req_ff.total_bytes, CTL_RTS};

   always_comb begin
      ev_status = STAT_OK;
      ev_kind   = KIND_STATUS;
      ev_conn   = 1'b0;
      ev_clear  = 1'b0;
      ev_write  = 1'b0;
      case (req_ff.func)
         FUNC_LOAD: begin
            if (12'(req_ff.byte_index) >= 12'(STORE_BYTES)) ev_status = STAT_RANGE;
            else ev_write = 1'b1;
         end
         FUNC_START: begin
            if (ses_ff != SES_IDLE) ev_status = STAT_STATE;
            else if (req_ff.total_bytes <= 9'd8 ||
                     12'(req_ff.total_bytes) > 12'(STORE_BYTES)) ev_status = STAT_LENGTH;
            else ev_kind = KIND_RTS;
         end
         FUNC_RX: begin
            case (b[0])
               CTL_CTS: begin
                  if (ses_ff == SES_IDLE) ev_status = STAT_STATE;
                  else if (ses_ff == SES_WAIT && !pgn_ok) ev_status = STAT_PGN;
                  else if (!rsv_ok) ev_status = STAT_RSV;
                  else begin
                     ev_conn = (ses_ff == SES_WAIT);
                     if (!pgn_ok) ev_status = STAT_PGN;
                     else if (b[1] == 8'd0) ev_status = STAT_ZERO;
                     else if (range_bad) ev_status = STAT_RANGE;
                     else ev_kind = KIND_BURST;
                  end
               end
               CTL_ACK: begin
                  if (ses_ff == SES_IDLE) ev_status = STAT_STATE;
                  else if (b[3] != {1'b0, tot_ff}) ev_status = STAT_LENGTH;
                  else if (b[4] != BYTE_PAD) ev_status = STAT_RSV;
                  else if (!pgn_ok) ev_status = STAT_PGN;
                  else ev_clear = 1'b1;
               end
               CTL_ABORT: begin
                  if (ses_ff == SES_IDLE) ev_status = STAT_STATE;
                  else if (b[1] != BYTE_PAD || b[2] != BYTE_PAD || !rsv_ok)
                     ev_status = STAT_RSV;
                  else if (!pgn_ok) ev_status = STAT_PGN;
                  else ev_clear = 1'b1;
               end
               default: ev_status = STAT_OK;
            endcase
         end
         default: ev_status = STAT_OK;
      endcase
   end

   // Final packet carries what is left after the full packets.
   assign last_len_full = {1'b0, len_ff} - 10'(({3'b0, tot_ff} - 10'd1) * 10'd7);
   assign len_p   = (pkt_ff == {1'b0, tot_ff}) ? last_len_full[2:0] : 3'd7;
   assign k       = 3'(j_ff - 4'd1);
   assign keep_byte = (k < len_p) ? rd_byte : BYTE_PAD;

   assign sm1  = 11'(b[2]) - 11'd1;
   assign base = (sm1 << 3) - sm1;

   assign id_cm = {prio_ff, 2'b00, PF_CM, dst_ff, src_ff};
   assign id_dt = {prio_ff, 2'b00, PF_DT, dst_ff, src_ff};

   rtscts_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
      .clock   (clock),
      .wr_en   (cmd.apply && ev_write),
      .wr_addr (AW'(req_ff.byte_index)),
      .wr_data (req_ff.data_byte),
      .rd_en   (cmd.rd_step && (j_ff < 4'd7)),
      .rd_addr (addr_ff),
      .rd_data (rd_byte)
   );

   always_ff @(posedge clock) begin
      if (cmd.latch) req_ff <= req_data;
      if (cmd.apply && ev_kind == KIND_BURST) begin
         pkt_ff  <= b[2];
         end_ff  <= 8'(count9 + strt9 - 9'd1);
         addr_ff <= base[AW-1:0];
      end
      if (cmd.rd_step) begin
         if (j_ff < 4'd7) addr_ff <= addr_ff + AW'(1);
         if (j_ff != 4'd0) buf_ff <= {keep_byte, buf_ff[55:8]};
      end
      if (cmd.emit) pkt_ff <= pkt_ff + 8'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ses_ff  <= SES_IDLE;
         pgn_ff  <= '0;
         len_ff  <= '0;
         tot_ff  <= '0;
         src_ff  <= 8'd244;
         dst_ff  <= 8'd86;
         prio_ff <= 3'd7;
         j_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_SRC:  src_ff  <= csr_data;
               CSR_DST:  dst_ff  <= csr_data;
               CSR_PRIO: prio_ff <= csr_data[2:0];
               default:  src_ff  <= src_ff;
            endcase
         end
         rsp_valid_ff <= 1'b0;
         if (cmd.apply) begin
            if (ev_clear) begin
               ses_ff <= SES_IDLE;
               pgn_ff <= '0;
               len_ff <= '0;
               tot_ff <= '0;
            end
            if (ev_conn) ses_ff <= SES_CONN;
            if (ev_kind == KIND_RTS) begin
               ses_ff <= SES_WAIT;
               pgn_ff <= req_ff.pgn_number;
               len_ff <= req_ff.total_bytes;
               tot_ff <= pk[6:0];
            end
            j_ff <= '0;
            rsp_valid_ff <= (ev_kind != KIND_BURST);
         end
         if (cmd.rd_step) j_ff <= j_ff + 4'd1;
         if (cmd.emit) begin
            j_ff <= '0;
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         if (ev_kind == KIND_RTS) begin
            rsp_ff <= '{has_frame: 1'b1, frame_id: id_cm, frame_bytes: rts_bytes,
                        frame_len: 4'd8, status: STAT_OK, last: 1'b1};
         end else begin
            rsp_ff <= '{has_frame: 1'b0, frame_id: '0, frame_bytes: '0,
                        frame_len: 4'd0, status: ev_status, last: 1'b1};
         end
      end
      if (cmd.emit) begin
         rsp_ff <= '{has_frame: 1'b1, frame_id: id_dt, frame_bytes: {buf_ff, pkt_ff},
                     frame_len: 4'd8, status: STAT_OK, last: (pkt_ff == end_ff)};
      end
   end

   assign sts.kind       = ev_kind;
   assign sts.rd_done    = (j_ff == 4'd7);
   assign sts.burst_last = (pkt_ff == end_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

@@ hw/rtl/rtscts_ctrl.sv @@
// Controller: sequences decode, store reads and frame emission.
// Depends on rtscts_pkg.
module rtscts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output rtscts_pkg::cmd_type cmd,
   input  rtscts_pkg::sts_type sts
);
   import rtscts_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.apply = 1'b1;
            state_in  = (sts.kind == KIND_BURST) ? S_READ : S_IDLE;
         end
         S_READ: begin
            cmd.rd_step = 1'b1;
            if (sts.rd_done) state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            state_in = sts.burst_last ? S_IDLE : S_READ;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);
endmodule

@@ hw/rtl/can_transport_rts_cts_sender_unit.sv @@
// Top level of the transport-protocol sender (request/clear-to-send).
// Depends on rtscts_pkg, rtscts_ctrl and rtscts_dp.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------
//  request  | start && !busy        | req_data  (rtscts_pkg::req_type)
//  response | rsp_valid, one cycle  | rsp_data  (rtscts_pkg::rsp_type)
//  csr      | csr_valid && csr_ready| csr_index, csr_data
//
// A request that yields a single result is latched, then decoded.
// In a clear-to-send burst, each data frame needs seven reads of the
// message store's one read port; the last read data then lands and the
// frame is presented.
// Reset returns session and configuration state to their defaults; the store is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module can_transport_rts_cts_sender_unit #(
   parameter int STORE_BYTES = 448,
   parameter int MAX_BURST   = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  rtscts_pkg::req_type req_data,
   output logic                rsp_valid,
   output rtscts_pkg::rsp_type rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_data
);
   import rtscts_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Registers are always writable; the user must write only while idle, the block does not check.
   assign csr_ready = 1'b1;

   // Sequence the request through decode, store reads and emission.
   rtscts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   // Hold session state, the store and the result register.
   rtscts_dp #(.STORE_BYTES(STORE_BYTES), .MAX_BURST(MAX_BURST)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );
endmodule

@@ hw/rtl/rtscts_checker.sv @@
// Port-level checks of the transport sender unit, bound to the top level.
// Depends on rtscts_pkg and can_transport_rts_cts_sender_unit_assert.svh.
`include "can_transport_rts_cts_sender_unit_assert.svh"
module rtscts_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input rtscts_pkg::rsp_type rsp_data,
   input logic                csr_valid,
   input logic                csr_ready
);
   import rtscts_pkg::*;

   `RTSCTS_ASSERT_IMP(a_nofr_last, clock, reset,
      rsp_valid && !rsp_data.has_frame, rsp_data.last,
      "status-only result must be last")
   `RTSCTS_ASSERT_IMP(a_err_nofr, clock, reset,
      rsp_valid && rsp_data.status != STAT_OK, !rsp_data.has_frame,
      "failed result carries a frame")
   `RTSCTS_ASSERT_IMP(a_idle_last, clock, reset,
      rsp_valid && !busy, rsp_data.last,
      "block idle after a non-final result")
   `RTSCTS_ASSERT_NXT(a_accept_busy, clock, reset,
      start && !busy, busy,
      "accepted request did not raise busy")
   `RTSCTS_ASSERT_IMP(a_csr_idle, clock, reset,
      csr_valid && csr_ready, !busy,
      "register write while a request is in flight")
endmodule

bind can_transport_rts_cts_sender_unit rtscts_checker u_chk (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench for the transport-protocol sender unit.
// Depends on rtscts_pkg and can_transport_rts_cts_sender_unit.
// Runs a directed stimulus table, then random sessions, and checks every result.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rtscts_pkg::*;

   localparam int STORE_BYTES = 448;
   localparam int MAX_BURST   = 64;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE      = 30;
   // Bytes written before any session; every session stays within them.
   localparam int FILL_BYTES  = 70;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [1:0] csr_index;
   logic [7:0] csr_data;

   can_transport_rts_cts_sender_unit #(
      .STORE_BYTES(STORE_BYTES),
      .MAX_BURST  (MAX_BURST)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   // One row of the directed table: the request, and where the answer is
   // obvious, the single result typed in by hand.
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } dir_row_type;

   // Shadow copy of the sender: configuration, session and message store.
   logic [7:0]  own_addr;
   logic [7:0]  peer_addr;
   logic [2:0]  prio;
   logic [1:0]  ses;
   logic [17:0] ses_pgn;
   int unsigned ses_len;
   int unsigned ses_pkts;
   logic [7:0]  msg_store [STORE_BYTES];

   rsp_type     frames_due[$];
   dir_row_type dir_rows[$];
   int unsigned n_fail;
   int unsigned n_in;
   int unsigned n_out;
   int unsigned n_data;
   int unsigned n_cycles;
   int unsigned idle_pct;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop: no correct run comes anywhere near this.
   initial n_cycles = 0;
   always @(posedge clock) begin
      n_cycles <= n_cycles + 1;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic rsp_type status_rsp(input logic [2:0] st);
      rsp_type r;
      r        = '0;
      r.status = st;
      r.last   = 1'b1;
      return r;
   endfunction

   function automatic logic [28:0] frame_ident(input logic [7:0] pf);
      return {prio, 2'b00, pf, peer_addr, own_addr};
   endfunction

   function automatic req_type mk_req(input logic [1:0] fn, input logic [8:0] idx,
                                      input logic [7:0] dat, input logic [17:0] pgn,
                                      input logic [8:0] tot, input logic [63:0] rx);
      req_type q;
      q.func        = fn;
      q.byte_index  = idx;
      q.data_byte   = dat;
      q.pgn_number  = pgn;
      q.total_bytes = tot;
      q.rx_frame    = rx;
      return q;
   endfunction

   function automatic logic [63:0] cts_frame(input logic [7:0] cnt, input logic [7:0] first,
                                             input logic [17:0] pgn);
      return {6'b0, pgn, BYTE_PAD, BYTE_PAD, first, cnt, CTL_CTS};
   endfunction

   function automatic logic [63:0] ack_frame(input logic [7:0] pkts, input logic [8:0] len,
                                             input logic [17:0] pgn);
      return {6'b0, pgn, BYTE_PAD, pkts, 7'b0, len[8], len[7:0], CTL_ACK};
   endfunction

   function automatic logic [63:0] abort_frame(input logic [17:0] pgn);
      return {6'b0, pgn, BYTE_PAD, BYTE_PAD, BYTE_PAD, BYTE_PAD, CTL_ABORT};
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Clear-to-send handling: checks in the block's order, then the burst.
   task automatic sender_cts(input logic [63:0] f);
      logic [23:0] pgn;
      int unsigned cnt, first, p, plen, idx;
      rsp_type     r;
      logic [63:0] bytes;
      logic [7:0]  b;
      pgn   = f[63:40];
      cnt   = f[15:8];
      first = f[23:16];
      if (ses == SES_IDLE) begin
         frames_due.push_back(status_rsp(STAT_STATE));
         return;
      end
      // First grant after the request: PGN first, then the reserved bytes.
      if (ses == SES_WAIT) begin
         if (pgn != {6'b0, ses_pgn}) begin
            frames_due.push_back(status_rsp(STAT_PGN));
            return;
         end
         if (f[31:24] != BYTE_PAD || f[39:32] != BYTE_PAD) begin
            frames_due.push_back(status_rsp(STAT_RSV));
            return;
         end
         ses = SES_CONN;
      end
      if (f[31:24] != BYTE_PAD || f[39:32] != BYTE_PAD) begin
         frames_due.push_back(status_rsp(STAT_RSV));
         return;
      end
      if (pgn != {6'b0, ses_pgn}) begin
         frames_due.push_back(status_rsp(STAT_PGN));
         return;
      end
      if (cnt == 0) begin
         frames_due.push_back(status_rsp(STAT_ZERO));
         return;
      end
      if (first == 0 || cnt > MAX_BURST || cnt + first - 1 > ses_pkts) begin
         frames_due.push_back(status_rsp(STAT_RANGE));
         return;
      end
      for (int i = 0; i < cnt; i++) begin
         p    = first + i;
         plen = 7;
         // Last packet carries the remainder, or a full seven when none.
         if (p == ses_pkts) begin
            plen = ses_len % 7;
            if (plen == 0) plen = 7;
         end
         bytes = {56'b0, p[7:0]};
         for (int j = 0; j < 7; j++) begin
            idx = (p - 1) * 7 + j;
            b   = (j < plen && idx < STORE_BYTES) ? msg_store[idx] : BYTE_PAD;
            bytes[8*(j+1) +: 8] = b;
         end
         r             = '0;
         r.has_frame   = 1'b1;
         r.frame_id    = frame_ident(PF_DT);
         r.frame_bytes = bytes;
         r.frame_len   = 4'd8;
         r.status      = STAT_OK;
         r.last        = (i == cnt - 1);
         frames_due.push_back(r);
      end
   endtask

   // Work out the results of one accepted transfer and queue them.
   task automatic sender_step(input req_type q);
      logic [7:0]  ctl;
      logic [63:0] f;
      int unsigned pk;
      rsp_type     r;
      f   = q.rx_frame;
      ctl = f[7:0];
      case (q.func)
         FUNC_LOAD: begin
            if (q.byte_index >= STORE_BYTES) begin
               frames_due.push_back(status_rsp(STAT_RANGE));
            end else begin
               msg_store[q.byte_index] = q.data_byte;
               frames_due.push_back(status_rsp(STAT_OK));
            end
         end
         FUNC_START: begin
            if (ses != SES_IDLE) begin
               frames_due.push_back(status_rsp(STAT_STATE));
            end else if (q.total_bytes <= 8 || q.total_bytes > STORE_BYTES) begin
               frames_due.push_back(status_rsp(STAT_LENGTH));
            end else begin
               pk       = (q.total_bytes + 6) / 7;
               ses_pgn  = q.pgn_number;
               ses_len  = q.total_bytes;
               ses_pkts = pk;
               ses      = SES_WAIT;
               r             = '0;
               r.has_frame   = 1'b1;
               r.frame_id    = frame_ident(PF_CM);
               r.frame_bytes = {6'b0, q.pgn_number, BYTE_PAD, pk[7:0], 7'b0,
                                q.total_bytes, CTL_RTS};
               r.frame_len   = 4'd8;
               r.last        = 1'b1;
               frames_due.push_back(r);
            end
         end
         FUNC_RX: begin
            if (ctl == CTL_CTS) begin
               sender_cts(f);
            end else if (ctl == CTL_ACK) begin
               if (ses == SES_IDLE) frames_due.push_back(status_rsp(STAT_STATE));
               else if (f[31:24] != ses_pkts[7:0]) frames_due.push_back(status_rsp(STAT_LENGTH));
               else if (f[39:32] != BYTE_PAD) frames_due.push_back(status_rsp(STAT_RSV));
               else if (f[63:40] != ses_pgn) frames_due.push_back(status_rsp(STAT_PGN));
               else begin
                  ses = SES_IDLE;
                  frames_due.push_back(status_rsp(STAT_OK));
               end
            end else if (ctl == CTL_ABORT) begin
               if (ses == SES_IDLE) frames_due.push_back(status_rsp(STAT_STATE));
               else if (f[39:8] != 32'hFFFF_FFFF) frames_due.push_back(status_rsp(STAT_RSV));
               else if (f[63:40] != ses_pgn) frames_due.push_back(status_rsp(STAT_PGN));
               else begin
                  ses = SES_IDLE;
                  frames_due.push_back(status_rsp(STAT_OK));
               end
            end else begin
               frames_due.push_back(status_rsp(STAT_OK));
            end
         end
         default: frames_due.push_back(status_rsp(STAT_OK));
      endcase
   endtask

   // Offer one request; hold it until the block takes it. A table row with a
   // typed answer replaces what the shadow model queued.
   task automatic send_req(input req_type q, input bit typed = 0,
                           input rsp_type want = '0);
      int unsigned depth;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
      n_in++;
      depth = frames_due.size();
      sender_step(q);
      if (typed) begin
         while (frames_due.size() > depth) void'(frames_due.pop_back());
         frames_due.push_back(want);
      end
   endtask

   // Drop start and hold off until every outstanding result is in.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (frames_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SRC:  own_addr  = val;
         CSR_DST:  peer_addr = val;
         CSR_PRIO: prio      = val[2:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [7:0] src, input logic [7:0] dst,
                             input logic [2:0] pr);
      csr_write(CSR_SRC, src);
      csr_write(CSR_DST, dst);
      csr_write(CSR_PRIO, {5'b0, pr});
   endtask

   function automatic void add_row(input req_type q, input bit typed = 0,
                                   input logic [2:0] st = STAT_OK);
      dir_row_type row;
      row.req   = q;
      row.typed = typed;
      row.rsp   = status_rsp(st);
      dir_rows.push_back(row);
   endfunction

   // Noise: any field pattern, any function, including malformed frames.
   // Start lengths stay within the filled bytes.
   task automatic send_noise();
      logic [63:0] f;
      f = rand64();
      case ($urandom_range(5))
         0: f[7:0] = CTL_CTS;
         1: f[7:0] = CTL_ACK;
         2: f[7:0] = CTL_ABORT;
         3: begin
            f = cts_frame(8'($urandom_range(70)), 8'($urandom_range(70)), ses_pgn);
            if ($urandom_range(1)) f[39:24] = 16'($urandom);
         end
         default: ;
      endcase
      send_req(mk_req(2'($urandom_range(3)), 9'($urandom), 8'($urandom), 18'($urandom),
                      9'($urandom_range(FILL_BYTES)), f));
   endtask

   // A well-formed session with random content: request, grants in chunks,
   // then acknowledge or abort. Lengths stay within the filled bytes.
   task automatic run_session();
      logic [17:0] pgn;
      logic [8:0]  len;
      int unsigned pk, nxt, cnt;
      // Close a session that noise left open.
      if (ses != SES_IDLE)
         send_req(mk_req(FUNC_RX, 0, 0, 0, 0, abort_frame(ses_pgn)));
      pgn = 18'($urandom);
      len = 9'($urandom_range(FILL_BYTES, 9));
      pk  = (len + 6) / 7;
      if ($urandom_range(3) == 0)
         send_req(mk_req(FUNC_LOAD, 9'($urandom_range(len - 1)), 8'($urandom), 0, 0, 0));
      send_req(mk_req(FUNC_START, 9'($urandom), 8'($urandom), pgn, len, rand64()));
      nxt = 1;
      while (nxt <= pk) begin
         if ($urandom_range(9) == 0) send_noise();
         cnt = $urandom_range((pk - nxt + 1 < 12) ? pk - nxt + 1 : 12, 1);
         send_req(mk_req(FUNC_RX, 9'($urandom), 8'($urandom), 18'($urandom), 9'($urandom),
                         cts_frame(8'(cnt), 8'(nxt), pgn)));
         // Advance, but now and then ask for the same packets again.
         if ($urandom_range(7) != 0) nxt += cnt;
      end
      if ($urandom_range(3) != 0)
         send_req(mk_req(FUNC_RX, 9'($urandom), 8'($urandom), 18'($urandom), 9'($urandom),
                         ack_frame(8'(pk), len, pgn)));
      else
         send_req(mk_req(FUNC_RX, 9'($urandom), 8'($urandom), 18'($urandom), 9'($urandom),
                         abort_frame(pgn)));
   endtask

   task automatic random_phase(input int unsigned quota);
      int unsigned goal;
      goal = n_in + quota;
      while (n_in < goal) begin
         if ($urandom_range(4) == 0) send_noise();
         else run_session();
      end
   endtask

   // Result checker: every strobe must match the oldest expectation.
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (frames_due.size() == 0) begin
            $error("unexpected result: %p", rsp_data);
            n_fail++;
         end else begin
            want = frames_due.pop_front();
            n_out++;
            if (rsp_data.has_frame) n_data++;
            if (rsp_data.has_frame !== want.has_frame) begin
               $error("has_frame: expected %0d, got %0d", want.has_frame, rsp_data.has_frame);
               n_fail++;
            end
            if (rsp_data.frame_id !== want.frame_id) begin
               $error("frame_id: expected %h, got %h", want.frame_id, rsp_data.frame_id);
               n_fail++;
            end
            if (rsp_data.frame_bytes !== want.frame_bytes) begin
               $error("frame_bytes: expected %h, got %h",
                      want.frame_bytes, rsp_data.frame_bytes);
               n_fail++;
            end
            if (rsp_data.frame_len !== want.frame_len) begin
               $error("frame_len: expected %0d, got %0d", want.frame_len, rsp_data.frame_len);
               n_fail++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               n_fail++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_data.last);
               n_fail++;
            end
         end
      end
   end

   localparam logic [17:0] PGN_A = 18'h3FFFF;
   localparam logic [17:0] PGN_B = 18'h00000;
   localparam logic [17:0] PGN_C = 18'h2A5C3;

   initial begin
      n_fail    = 0;
      n_in      = 0;
      n_out     = 0;
      n_data    = 0;
      idle_pct  = 23;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SRC;
      csr_data  = '0;
      own_addr  = 8'd244;
      peer_addr = 8'd86;
      prio      = 3'd7;
      ses       = SES_IDLE;
      ses_pgn   = '0;
      ses_len   = 0;
      ses_pkts  = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the front of the store; no session ever reads past it.
      for (int i = 0; i < FILL_BYTES; i++)
         send_req(mk_req(FUNC_LOAD, 9'(i), 8'($urandom), 18'($urandom), 9'($urandom),
                         rand64()));

      // Directed table: out-of-range loads, unknown function, idle-state
      // errors, bad lengths, every check of grant, acknowledge and abort,
      // a full-size session and a length that is a multiple of seven.
      add_row(mk_req(FUNC_LOAD, 448, 8'hFF, 0, 0, 0), 1, STAT_RANGE);
      add_row(mk_req(FUNC_LOAD, 511, 8'h00, 0, 0, 0), 1, STAT_RANGE);
      add_row(mk_req(2'd3, 0, 0, PGN_A, 9'd20, '1), 1, STAT_OK);
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, cts_frame(1, 1, PGN_B)), 1, STAT_STATE);
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, ack_frame(3, 16, PGN_B)), 1, STAT_STATE);
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, abort_frame(PGN_B)), 1, STAT_STATE);
      add_row(mk_req(FUNC_START, 0, 0, PGN_A, 9'd8, 0), 1, STAT_LENGTH);
      add_row(mk_req(FUNC_START, 0, 0, PGN_A, 9'd449, 0), 1, STAT_LENGTH);
      add_row(mk_req(FUNC_START, 0, 0, PGN_A, 9'd0, 0), 1, STAT_LENGTH);
      add_row(mk_req(FUNC_START, 0, 0, PGN_A, 9'd16, 0));
      add_row(mk_req(FUNC_START, 0, 0, PGN_A, 9'd16, 0), 1, STAT_STATE);
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, cts_frame(1, 1, PGN_C)), 1, STAT_PGN);
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, {cts_frame(1, 1, PGN_A)} & ~(64'hFF << 32)),
              1, STAT_RSV);
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, cts_frame(0, 1, PGN_A)), 1, STAT_ZERO);
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, cts_frame(2, 0, PGN_A)), 1, STAT_RANGE);
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, cts_frame(3, 2, PGN_A)), 1, STAT_RANGE);
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, cts_frame(3, 1, PGN_A)));
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, ack_frame(2, 16, PGN_A)), 1, STAT_LENGTH);
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, ack_frame(3, 16, PGN_A) & ~(64'hFF << 32)),
              1, STAT_RSV);
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, ack_frame(3, 16, PGN_C)), 1, STAT_PGN);
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, ack_frame(3, 16, PGN_A)), 1, STAT_OK);
      add_row(mk_req(FUNC_START, 0, 0, PGN_B, 9'd448, 0));
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, cts_frame(65, 1, PGN_B)), 1, STAT_RANGE);
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, cts_frame(10, 1, PGN_B)));
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, abort_frame(PGN_B) & ~(64'hFF << 16)), 1, STAT_RSV);
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, abort_frame(PGN_C)), 1, STAT_PGN);
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, abort_frame(PGN_B)), 1, STAT_OK);
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, 64'h22), 1, STAT_OK);
      add_row(mk_req(FUNC_START, 0, 0, PGN_C, 9'd14, 0));
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, cts_frame(2, 1, PGN_C)));
      add_row(mk_req(FUNC_RX, 0, 0, 0, 0, ack_frame(2, 14, PGN_C)), 1, STAT_OK);
      foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
      drain();

      // Random part: all-zero identifier fields, sender idling lightly.
      set_config(8'd0, 8'd0, 3'd0);
      random_phase(40);
      drain();

      // All-ones identifier fields, sender idling most of the time.
      idle_pct = 85;
      set_config(8'hFF, 8'hFF, 3'd7);
      random_phase(40);
      drain();

      // Random addresses, back-to-back transfers.
      idle_pct = 0;
      set_config(8'($urandom), 8'($urandom), 3'($urandom));
      random_phase(40);
      drain();

      $display("tb: run covered %0d transfers in and %0d results out (%0d frames)",
               n_in, n_out, n_data);
      if (n_fail == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/rtscts_pkg.sv
hw/rtl/rtscts_ram.sv
hw/rtl/rtscts_dp.sv
hw/rtl/rtscts_ctrl.sv
hw/rtl/can_transport_rts_cts_sender_unit.sv
hw/rtl/rtscts_checker.sv
verif/tb_top.sv
